[rtl/cem_pkg.sv]
// Package for the cron entry matcher: item structs, part and op codes,
// back-end state enum and default sizes. No dependencies.
`default_nettype none

package cem_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int NumEntriesDef  = 16;
  localparam int NumCommandsDef = 16;

  // Widths fixed by the item fields.
  localparam int ValueW = 60;
  localparam int IdxW   = 4;
  localparam int CmdW   = 4;
  localparam int MinW   = 60;
  localparam int HourW  = 24;
  localparam int DomW   = 31;
  localparam int MonW   = 12;
  localparam int DowW   = 8;
  localparam int FlagW  = 5;
  localparam int NumParts = 7;

  // Flag bit positions.
  localparam int FlagValid   = 0;
  localparam int FlagMinStar = 1;
  localparam int FlagHrStar  = 2;
  localparam int FlagDomStar = 3;
  localparam int FlagDowStar = 4;

  typedef enum logic [2:0] {
    PART_MIN   = 3'd0,
    PART_HOUR  = 3'd1,
    PART_DOM   = 3'd2,
    PART_MONTH = 3'd3,
    PART_DOW   = 3'd4,
    PART_FLAGS = 3'd5,
    PART_CMD   = 3'd6,
    PART_NONE  = 3'd7
  } part_e;

  typedef enum logic [0:0] {
    REQ_WRITE = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } back_state_e;

  typedef struct packed {
    logic              req_type;
    logic [IdxW-1:0]   entry_index;
    logic [2:0]        part_select;
    logic [ValueW-1:0] part_value;
    logic [5:0]        tick_minute;
    logic [4:0]        tick_hour;
    logic [4:0]        tick_day_of_month;
    logic [3:0]        tick_month;
    logic [2:0]        tick_weekday;
    logic              run_wild;
    logic              run_fixed;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0] fired_entry;
    logic [CmdW-1:0] fired_command;
    logic            last_of_run;
  } out_item_t;

  // Classified operation passed from front to back.
  typedef struct packed {
    req_e              op;
    logic [IdxW-1:0]   idx;
    part_e             part;
    logic [ValueW-1:0] value;   // masked and ready to store
    logic [MinW-1:0]   min_oh;  // one-hot tick selects, zero when out of range
    logic [HourW-1:0]  hour_oh;
    logic [DomW-1:0]   dom_oh;
    logic [MonW-1:0]   mon_oh;
    logic [DowW-1:0]   dow_oh;
    logic              run_wild;
    logic              run_fixed;
  } op_item_t;

endpackage

`default_nettype wire

[rtl/cem_front.sv]
// Front end: classifies input items, drops writes with an out-of-range entry, part
// or command, masks write data and decodes tick time into one-hot selects. Uses cem_pkg.
`default_nettype none

module cem_front #(
  parameter int NumEntries  = cem_pkg::NumEntriesDef,
  parameter int NumCommands = cem_pkg::NumCommandsDef
) (
  input  cem_pkg::in_item_t item_i,
  input  logic              valid_i,
  output logic              push_o,
  output cem_pkg::op_item_t op_o
);
  import cem_pkg::*;

  logic       keep;
  logic [7:0] dow_val;

  always_comb begin
    op_o          = '0;
    op_o.op       = req_e'(item_i.req_type);
    op_o.idx      = item_i.entry_index;
    op_o.part     = part_e'(item_i.part_select);
    op_o.run_wild  = item_i.run_wild;
    op_o.run_fixed = item_i.run_fixed;
    keep          = 1'b1;
    dow_val       = item_i.part_value[7:0];
    if (dow_val[0] || dow_val[7]) begin
      dow_val = dow_val | 8'h81;
    end

    if (op_o.op == REQ_TICK) begin
      if (item_i.tick_minute < 6'd60) begin
        op_o.min_oh = MinW'(1) << item_i.tick_minute;
      end
      if (item_i.tick_hour < 5'd24) begin
        op_o.hour_oh = HourW'(1) << item_i.tick_hour;
      end
      if (item_i.tick_day_of_month != 5'd0) begin
        op_o.dom_oh = DomW'(1) << (item_i.tick_day_of_month - 5'd1);
      end
      if (item_i.tick_month != 4'd0 && item_i.tick_month <= 4'd12) begin
        op_o.mon_oh = MonW'(1) << (item_i.tick_month - 4'd1);
      end
      op_o.dow_oh = DowW'(1) << item_i.tick_weekday;
    end else begin
      if ({3'b000, item_i.entry_index} >= 7'(NumEntries)) begin
        keep = 1'b0;
      end
      case (op_o.part)
        PART_MIN:   op_o.value = item_i.part_value;
        PART_HOUR:  op_o.value = ValueW'(item_i.part_value[HourW-1:0]);
        PART_DOM:   op_o.value = ValueW'(item_i.part_value[DomW-1:0]);
        PART_MONTH: op_o.value = ValueW'(item_i.part_value[MonW-1:0]);
        PART_DOW:   op_o.value = ValueW'(dow_val);
        PART_FLAGS: op_o.value = ValueW'(item_i.part_value[FlagW-1:0]);
        PART_CMD: begin
          op_o.value = ValueW'(item_i.part_value[CmdW-1:0]);
          // command must fit the field and the command range
          if (item_i.part_value[ValueW-1:CmdW] != '0 ||
              {5'b00000, item_i.part_value[CmdW-1:0]} >= 9'(NumCommands)) begin
            keep = 1'b0;
          end
        end
        default: keep = 1'b0;
      endcase
    end
  end

  assign push_o = valid_i && keep;

endmodule

`default_nettype wire

[rtl/cem_fifo.sv]
// Two-entry queue of classified operations between front and back.
// Uses cem_pkg for the op item type.
`default_nettype none

module cem_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cem_pkg::op_item_t push_item_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output cem_pkg::op_item_t item_o
);
  import cem_pkg::*;

  op_item_t   mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");

  a_ptr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 || cnt_q == 2'd0) |-> wptr_q == rptr_q)
    else $error("queue pointers out of step with count");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

`default_nettype wire

[rtl/cem_back.sv]
// Back end: entry table memories, write execution and the one-entry-per-cycle
// tick scan (paused while a result waits on a stalled output) with output register. Uses cem_pkg.
`default_nettype none

module cem_back #(
  parameter int NumEntries = cem_pkg::NumEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  cem_pkg::op_item_t  q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cem_pkg::out_item_t out_item_o
);
  import cem_pkg::*;

  localparam int AddrW = (NumEntries > 1) ? $clog2(NumEntries) : 1;
  localparam int CntW  = $clog2(NumEntries + 1);

  back_state_e state_q, state_d;

  // table memories
  logic [MinW-1:0]  min_mem  [NumEntries];
  logic [HourW-1:0] hour_mem [NumEntries];
  logic [DomW-1:0]  dom_mem  [NumEntries];
  logic [MonW-1:0]  mon_mem  [NumEntries];
  logic [DowW-1:0]  dow_mem  [NumEntries];
  logic [FlagW-1:0] flag_mem [NumEntries];
  logic [CmdW-1:0]  cmd_mem  [NumEntries];
  // written-since-reset bits, one row per part
  logic [NumParts-1:0][NumEntries-1:0] pv_q;

  // registered read data
  logic [MinW-1:0]     min_rd_q;
  logic [HourW-1:0]    hour_rd_q;
  logic [DomW-1:0]     dom_rd_q;
  logic [MonW-1:0]     mon_rd_q;
  logic [DowW-1:0]     dow_rd_q;
  logic [FlagW-1:0]    flag_rd_q;
  logic [CmdW-1:0]     cmd_rd_q;
  logic [NumParts-1:0] rd_pv_q;

  op_item_t        tick_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rv_q, rv_d;
  logic [AddrW-1:0] ri_q, ri_d;
  logic            pend_q, pend_d;
  logic [AddrW-1:0] pend_entry_q, pend_entry_d;
  logic [CmdW-1:0] pend_cmd_q, pend_cmd_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  logic             wr_en, rd_en, tick_load;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [MinW-1:0]  min_eff;
  logic [HourW-1:0] hour_eff;
  logic [DomW-1:0]  dom_eff;
  logic [MonW-1:0]  mon_eff;
  logic [DowW-1:0]  dow_eff;
  logic [FlagW-1:0] flag_eff;
  logic [CmdW-1:0]  cmd_eff;
  logic dom_hit, dow_hit, day_ok, wild, pass, match;
  logic scan_done, emit_mid, emit_end, emit, out_can, hold;

  assign wr_addr = AddrW'(q_item_i.idx);
  assign rd_addr = idx_q[AddrW-1:0];

  // match evaluation on registered read data
  always_comb begin
    min_eff  = rd_pv_q[PART_MIN]   ? min_rd_q  : '0;
    hour_eff = rd_pv_q[PART_HOUR]  ? hour_rd_q : '0;
    dom_eff  = rd_pv_q[PART_DOM]   ? dom_rd_q  : '0;
    mon_eff  = rd_pv_q[PART_MONTH] ? mon_rd_q  : '0;
    dow_eff  = rd_pv_q[PART_DOW]   ? dow_rd_q  : '0;
    flag_eff = rd_pv_q[PART_FLAGS] ? flag_rd_q : '0;
    cmd_eff  = rd_pv_q[PART_CMD]   ? cmd_rd_q  : '0;
    dom_hit  = |(dom_eff & tick_q.dom_oh);
    dow_hit  = |(dow_eff & tick_q.dow_oh);
    day_ok   = (flag_eff[FlagDomStar] || flag_eff[FlagDowStar]) ?
               (dom_hit && dow_hit) : (dom_hit || dow_hit);
    wild     = flag_eff[FlagMinStar] || flag_eff[FlagHrStar];
    pass     = (tick_q.run_fixed && !wild) || (tick_q.run_wild && wild);
    match    = rv_q && flag_eff[FlagValid] &&
               (|(min_eff & tick_q.min_oh)) && (|(hour_eff & tick_q.hour_oh)) &&
               (|(mon_eff & tick_q.mon_oh)) && day_ok && pass;
  end

  // a match waits in a pending register until the next match or the scan end, so the final one can carry last_of_run
  always_comb begin
    scan_done = (state_q == BK_SCAN) && (idx_q == CntW'(NumEntries)) && !rv_q;
    emit_mid  = match && pend_q;
    emit_end  = scan_done && pend_q;
    emit      = emit_mid || emit_end;
    out_can   = !out_valid_q || !out_stall_i;
    hold      = emit && !out_can;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && q_item_i.op == REQ_TICK) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done && !hold) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    q_pop_o   = 1'b0;
    wr_en     = 1'b0;
    tick_load = 1'b0;
    rd_en     = 1'b0;
    case (state_q)
      BK_IDLE: begin
        q_pop_o   = q_valid_i;
        wr_en     = q_valid_i && (q_item_i.op == REQ_WRITE);
        tick_load = q_valid_i && (q_item_i.op == REQ_TICK);
      end
      BK_SCAN: begin
        rd_en = !hold && (idx_q != CntW'(NumEntries));
      end
      default: ;
    endcase
  end

  // scan datapath
  always_comb begin
    idx_d        = idx_q;
    rv_d         = rv_q;
    ri_d         = ri_q;
    pend_d       = pend_q;
    pend_entry_d = pend_entry_q;
    pend_cmd_d   = pend_cmd_q;
    if (tick_load) begin
      idx_d  = '0;
      rv_d   = 1'b0;
      pend_d = 1'b0;
    end else if (state_q == BK_SCAN && !hold) begin
      if (match) begin
        pend_d       = 1'b1;
        pend_entry_d = ri_q;
        pend_cmd_d   = cmd_eff;
      end else if (emit_end) begin
        pend_d = 1'b0;
      end
      rv_d = rd_en;
      if (rd_en) begin
        idx_d = idx_q + CntW'(1);
        ri_d  = rd_addr;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit && out_can) begin
      out_valid_d         = 1'b1;
      out_d.fired_entry   = IdxW'(pend_entry_q);
      out_d.fired_command = pend_cmd_q;
      out_d.last_of_run   = emit_end;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (q_item_i.part)
        PART_MIN:   min_mem[wr_addr]  <= q_item_i.value[MinW-1:0];
        PART_HOUR:  hour_mem[wr_addr] <= q_item_i.value[HourW-1:0];
        PART_DOM:   dom_mem[wr_addr]  <= q_item_i.value[DomW-1:0];
        PART_MONTH: mon_mem[wr_addr]  <= q_item_i.value[MonW-1:0];
        PART_DOW:   dow_mem[wr_addr]  <= q_item_i.value[DowW-1:0];
        PART_FLAGS: flag_mem[wr_addr] <= q_item_i.value[FlagW-1:0];
        PART_CMD:   cmd_mem[wr_addr]  <= q_item_i.value[CmdW-1:0];
        default: ;
      endcase
    end
    if (rd_en) begin
      min_rd_q  <= min_mem[rd_addr];
      hour_rd_q <= hour_mem[rd_addr];
      dom_rd_q  <= dom_mem[rd_addr];
      mon_rd_q  <= mon_mem[rd_addr];
      dow_rd_q  <= dow_mem[rd_addr];
      flag_rd_q <= flag_mem[rd_addr];
      cmd_rd_q  <= cmd_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (tick_load) begin
      tick_q <= q_item_i;
    end
    ri_q         <= ri_d;
    pend_entry_q <= pend_entry_d;
    pend_cmd_q   <= pend_cmd_d;
    out_q        <= out_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pv_q        <= '0;
      rd_pv_q     <= '0;
      idx_q       <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (wr_en && q_item_i.part != PART_NONE) begin
        pv_q[q_item_i.part][wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        for (int p = 0; p < NumParts; p++) begin
          rd_pv_q[p] <= pv_q[p][rd_addr];
        end
      end
    end
  end

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> !pend_q && !rv_q)
    else $error("scan state left over in idle");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= CntW'(NumEntries)) else $error("scan index past table");

  a_rd_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> idx_q == CntW'(ri_q) + CntW'(1))
    else $error("read data index out of step with scan counter");

  a_emit_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> state_q == BK_SCAN) else $error("scan ended during output hold");

endmodule

`default_nettype wire

[rtl/cron_entry_matcher_core.sv]
// Top level of the cron entry matcher: front classifier, op queue and back
// scanner. Depends on cem_pkg, cem_front, cem_fifo and cem_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes write items,
//   which store one part of one table entry, and tick items (time, run enables).
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives one item per
//   entry that fires on a tick, in ascending entry order; the last item of a
//   tick has last_of_run set. A tick with no firing entry gives no item.
// Flow:
//   An item passes the front combinationally into a two-deep queue. A write
//   at the queue head is stored while the back end is idle. A tick is loaded
//   from the head and scanned one entry per cycle through the registered read
//   port, pausing while a result waits on a stalled output. A match waits in a
//   pending register and moves to the output register when the next match is
//   found or the scan ends.
// Reset: every entry reads as all zero (invalid) through per-part written
//   bits; no clearing pass is needed.
// Stalls: a stalled output holds its item; the scan pauses when a result is
//   ready while the output register is still stalled, and the queue absorbs
//   up to two more input items before in_stall_o.
`default_nettype none

module cron_entry_matcher_core #(
  parameter int NumEntries  = cem_pkg::NumEntriesDef,
  parameter int NumCommands = cem_pkg::NumCommandsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cem_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cem_pkg::out_item_t out_item_o
);
  import cem_pkg::*;

  op_item_t front_op;
  op_item_t head_op;
  logic     front_push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  // dropped writes are accepted and discarded by the front
  assign in_stall_o = q_full;

  cem_front #(
    .NumEntries (NumEntries),
    .NumCommands(NumCommands)
  ) u_front (
    .item_i (in_item_i),
    .valid_i(in_valid_i && !q_full),
    .push_o (front_push),
    .op_o   (front_op)
  );

  cem_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_push),
    .push_item_i(front_op),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .item_o     (head_op)
  );

  cem_back #(
    .NumEntries(NumEntries)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (head_op),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

[test/cron_entry_matcher_core_tb.sv]
// Testbench for cron_entry_matcher_core: writes schedule entries, sends time
// ticks and checks every fired entry against a table predictor kept here.
// Depends on cem_pkg and the cron_entry_matcher_core RTL.
`default_nettype none

module cron_entry_matcher_core_tb;
  import cem_pkg::*;

  localparam int NumEnt     = NumEntriesDef;
  localparam int NumCmd     = NumCommandsDef;
  localparam int MaxFired   = 16;
  // Longest output hold-off used to back the block up.
  localparam int LongHold   = 150;
  // Cycles with no item moving on either side before the run is abandoned.
  localparam int QuietLimit = 2000;
  // Tail wait after the final drain, sized from the table depth.
  localparam int TailCycles = 2 * NumEnt + 10;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  cron_entry_matcher_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Shadow copy of the schedule table.
  logic [MinW-1:0]  min_tab   [NumEnt];
  logic [HourW-1:0] hour_tab  [NumEnt];
  logic [DomW-1:0]  dom_tab   [NumEnt];
  logic [MonW-1:0]  mon_tab   [NumEnt];
  logic [DowW-1:0]  dow_tab   [NumEnt];
  logic [FlagW-1:0] flag_tab  [NumEnt];
  logic [CmdW-1:0]  cmd_tab   [NumEnt];

  // Fired entries still owed by the block, oldest first.
  out_item_t fires_pending[$];

  int  err_cnt       = 0;
  int  quiet_cycles  = 0;
  bit  gaps_on       = 1'b1;  // random idling on both sides
  bit  long_hold_req = 1'b0;  // ask the receiver for one long hold-off

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A write stores one part of one entry, masked to the part's width.
  function automatic void store_part(in_item_t it);
    logic [DowW-1:0] d;
    case (part_e'(it.part_select))
      PART_MIN:   min_tab[it.entry_index]  = it.part_value[MinW-1:0];
      PART_HOUR:  hour_tab[it.entry_index] = it.part_value[HourW-1:0];
      PART_DOM:   dom_tab[it.entry_index]  = it.part_value[DomW-1:0];
      PART_MONTH: mon_tab[it.entry_index]  = it.part_value[MonW-1:0];
      PART_DOW: begin
        // Sunday is both bit 0 and bit 7
        d = it.part_value[DowW-1:0];
        if (d[0] || d[7]) d = d | 8'h81;
        dow_tab[it.entry_index] = d;
      end
      PART_FLAGS: flag_tab[it.entry_index] = it.part_value[FlagW-1:0];
      PART_CMD: begin
        // out-of-range command keeps the old one
        if (it.part_value < NumCmd && it.part_value < (1 << CmdW))
          cmd_tab[it.entry_index] = it.part_value[CmdW-1:0];
      end
      default: ;
    endcase
  endfunction

  // A tick queues one fired entry per match, in ascending index order.
  function automatic void predict_fires(in_item_t it);
    out_item_t  run_q[$];
    out_item_t  r;
    int         mi, hr, da, mo, wd;
    logic [FlagW-1:0] f;
    bit min_ok, hr_ok, mon_ok, dom_hit, dow_hit, day_ok, wild;
    mi = int'(it.tick_minute);
    hr = int'(it.tick_hour);
    da = int'(it.tick_day_of_month);
    mo = int'(it.tick_month);
    wd = int'(it.tick_weekday);
    for (int i = 0; i < NumEnt && run_q.size() < MaxFired; i++) begin
      f = flag_tab[i];
      if (!f[FlagValid]) continue;
      // out-of-range time fields select no bit
      min_ok  = (mi < MinW) && min_tab[i][mi];
      hr_ok   = (hr < HourW) && hour_tab[i][hr];
      mon_ok  = (mo >= 1) && (mo <= MonW) && mon_tab[i][mo - 1];
      if (!(min_ok && hr_ok && mon_ok)) continue;
      dom_hit = (da >= 1) && dom_tab[i][da - 1];
      dow_hit = dow_tab[i][wd];
      // a starred day field needs both day tests, otherwise either one
      if (f[FlagDomStar] || f[FlagDowStar]) day_ok = dom_hit && dow_hit;
      else                                  day_ok = dom_hit || dow_hit;
      if (!day_ok) continue;
      wild = f[FlagMinStar] || f[FlagHrStar];
      if (!((it.run_fixed && !wild) || (it.run_wild && wild))) continue;
      r.fired_entry   = i[IdxW-1:0];
      r.fired_command = cmd_tab[i];
      r.last_of_run   = 1'b0;
      run_q.push_back(r);
    end
    if (run_q.size() > 0) run_q[run_q.size() - 1].last_of_run = 1'b1;
    foreach (run_q[k]) fires_pending.push_back(run_q[k]);
  endfunction

  function automatic void apply_item(in_item_t it);
    if (req_e'(it.req_type) == REQ_WRITE) store_part(it);
    else                                  predict_fires(it);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------

  // Fields that an item does not use carry random bits.
  function automatic in_item_t noise_item();
    in_item_t   it;
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    it.req_type          = 1'($urandom_range(0, 1));
    it.entry_index       = 4'($urandom_range(0, 15));
    it.part_select       = 3'($urandom_range(0, 7));
    it.part_value        = r[ValueW-1:0];
    it.tick_minute       = 6'($urandom_range(0, 63));
    it.tick_hour         = 5'($urandom_range(0, 31));
    it.tick_day_of_month = 5'($urandom_range(0, 31));
    it.tick_month        = 4'($urandom_range(0, 15));
    it.tick_weekday      = 3'($urandom_range(0, 7));
    it.run_wild          = 1'($urandom_range(0, 1));
    it.run_fixed         = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t write_item(int idx, part_e part, logic [ValueW-1:0] val);
    in_item_t it;
    it             = noise_item();
    it.req_type    = REQ_WRITE;
    it.entry_index = IdxW'(idx);
    it.part_select = part;
    it.part_value  = val;
    return it;
  endfunction

  function automatic in_item_t tick_item(int mi, int hr, int da, int mo, int wd,
                                         bit wild_en, bit fixed_en);
    in_item_t it;
    it                   = noise_item();
    it.req_type          = REQ_TICK;
    it.tick_minute       = 6'(mi);
    it.tick_hour         = 5'(hr);
    it.tick_day_of_month = 5'(da);
    it.tick_month        = 4'(mo);
    it.tick_weekday      = 3'(wd);
    it.run_wild          = wild_en;
    it.run_fixed         = fixed_en;
    return it;
  endfunction

  // Mostly well-formed traffic: dense masks, valid entries, in-range ticks.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    it = noise_item();
    if ($urandom_range(0, 9) < 4) begin
      it.req_type = REQ_WRITE;
      pick = $urandom_range(0, 15);
      it.part_select = (pick == 15) ? PART_NONE : 3'(pick % NumParts);
      case (part_e'(it.part_select))
        PART_FLAGS: it.part_value[FlagValid] = ($urandom_range(0, 4) != 0);
        PART_CMD: begin
          if ($urandom_range(0, 5) != 0) it.part_value = ValueW'($urandom_range(0, 15));
        end
        PART_NONE: ;
        default: begin
          if ($urandom_range(0, 9) < 3) it.part_value = '1;
        end
      endcase
    end else begin
      it.req_type = REQ_TICK;
      if ($urandom_range(0, 9) != 0) begin
        it.tick_minute       = 6'($urandom_range(0, 59));
        it.tick_hour         = 5'($urandom_range(0, 23));
        it.tick_day_of_month = 5'($urandom_range(1, 31));
        it.tick_month        = 4'($urandom_range(1, 12));
        it.tick_weekday      = 3'($urandom_range(0, 6));
      end
      if ($urandom_range(0, 9) < 7) begin
        it.run_wild  = 1'b1;
        it.run_fixed = 1'b1;
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Tasks start and end on a falling edge; valid may still be high
  // from the item just taken, so anything that does not send drops it first.
  // ---------------------------------------------------------------------------

  task automatic send_item(input in_item_t it);
    int gap;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(it);
    @(negedge clk_i);
  endtask

  // Sender holds off until every fired entry owed so far has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (fires_pending.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset every entry is invalid, so no tick fires anything.
  task automatic test_empty_table();
    send_item(tick_item(0, 0, 1, 1, 0, 1'b1, 1'b1));
    send_item(tick_item(59, 23, 31, 12, 6, 1'b1, 1'b1));
  endtask

  // Field extremes, every part, Sunday aliasing, ignored writes and
  // out-of-range tick times.
  task automatic test_part_edges();
    logic [ValueW-1:0] all_ones;
    all_ones = '1;
    // entry 0: full masks, day star, Sunday given as bit 0
    send_item(write_item(0, PART_MIN, all_ones));
    send_item(write_item(0, PART_HOUR, all_ones));
    send_item(write_item(0, PART_DOM, all_ones));
    send_item(write_item(0, PART_MONTH, all_ones));
    send_item(write_item(0, PART_DOW, 60'h1));
    send_item(write_item(0, PART_FLAGS, 60'((1 << FlagValid) | (1 << FlagDomStar))));
    send_item(write_item(0, PART_CMD, 60'd16));      // too large, dropped
    send_item(write_item(0, PART_CMD, all_ones));    // too large, dropped
    send_item(write_item(0, PART_CMD, 60'd15));
    send_item(write_item(0, PART_NONE, all_ones));   // unknown part, dropped
    // entry 15: top bits only, minute star, Sunday given as bit 7
    send_item(write_item(15, PART_MIN, 60'(1) << 59));
    send_item(write_item(15, PART_HOUR, 60'(1) << 23));
    send_item(write_item(15, PART_DOM, 60'(1) << 30));
    send_item(write_item(15, PART_MONTH, 60'(1) << 11));
    send_item(write_item(15, PART_DOW, 60'h80));
    send_item(write_item(15, PART_FLAGS, 60'((1 << FlagValid) | (1 << FlagMinStar))));
    // both fire, then each one alone through the run enables and day rules
    send_item(tick_item(59, 23, 31, 12, 0, 1'b1, 1'b1));
    send_item(tick_item(59, 23, 31, 12, 7, 1'b0, 1'b1));
    send_item(tick_item(59, 23, 31, 12, 3, 1'b1, 1'b0));
    // out-of-range tick fields
    send_item(tick_item(60, 23, 31, 12, 0, 1'b1, 1'b1));
    send_item(tick_item(0, 24, 1, 1, 0, 1'b1, 1'b1));
    send_item(tick_item(5, 3, 0, 5, 0, 1'b1, 1'b1));
    send_item(tick_item(5, 3, 9, 0, 0, 1'b1, 1'b1));
    send_item(tick_item(5, 3, 9, 13, 0, 1'b1, 1'b1));
    send_item(tick_item(63, 31, 31, 15, 7, 1'b0, 1'b0));
  endtask

  // Every entry fires on every tick; the output is held off long enough for
  // the input to back up, then the sender waits for the full drain.
  task automatic test_backpressure();
    logic [ValueW-1:0] all_ones;
    all_ones = '1;
    for (int e = 0; e < NumEnt; e++) begin
      send_item(write_item(e, PART_MIN, all_ones));
      send_item(write_item(e, PART_HOUR, all_ones));
      send_item(write_item(e, PART_DOM, all_ones));
      send_item(write_item(e, PART_MONTH, all_ones));
      send_item(write_item(e, PART_FLAGS, 60'(1 << FlagValid)));
    end
    wait_drained();
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (4) send_item(tick_item($urandom_range(0, 59), $urandom_range(0, 23),
                                   $urandom_range(1, 31), $urandom_range(1, 12),
                                   $urandom_range(0, 6), 1'b1, 1'b1));
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int n_items);
    for (int k = 0; k < n_items; k++) send_item(random_item());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    // the table is all zero after reset
    for (int e = 0; e < NumEnt; e++) begin
      min_tab[e]  = '0;
      hour_tab[e] = '0;
      dom_tab[e]  = '0;
      mon_tab[e]  = '0;
      dow_tab[e]  = '0;
      flag_tab[e] = '0;
      cmd_tab[e]  = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_part_edges();
    test_backpressure();
    test_random_traffic(80);
    gaps_on = 1'b0;   // quiet tail: no idling on either side
    test_random_traffic(20);

    wait_drained();
    repeat (TailCycles) @(negedge clk_i);
    if (err_cnt == 0 && fires_pending.size() == 0) begin
      $display("PASS cron_entry_matcher_core");
    end else begin
      $display("FAIL cron_entry_matcher_core");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver: random stall bursts while idling is on, one long hold on request.
  initial begin : out_stall_drv
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Each fired entry taken is compared with the oldest one owed.
  always @(posedge clk_i) begin : check_fires
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fires_pending.size() == 0) begin
        $error("unexpected fired entry %0d command %0d",
               out_item_o.fired_entry, out_item_o.fired_command);
        err_cnt++;
      end else begin
        want = fires_pending.pop_front();
        if (out_item_o.fired_entry !== want.fired_entry) begin
          $error("fired_entry: expected %0d, got %0d",
                 want.fired_entry, out_item_o.fired_entry);
          err_cnt++;
        end
        if (out_item_o.fired_command !== want.fired_command) begin
          $error("fired_command: expected %0d, got %0d",
                 want.fired_command, out_item_o.fired_command);
          err_cnt++;
        end
        if (out_item_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d",
                 want.last_of_run, out_item_o.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL cron_entry_matcher_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire
